FILE: rtl/core/multichannel_ramp_hold_generator_unit_macros.svh
// Assertion helpers for the ramp and hold generator.
`ifndef MULTICHANNEL_RAMP_HOLD_GENERATOR_UNIT_MACROS_SVH
`define MULTICHANNEL_RAMP_HOLD_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MRHG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MRHG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mrhg_pkg.sv
`default_nettype none
package mrhg_pkg;

    localparam int COS_TABLE_DEPTH = 256;
    localparam int TAB_AW = $clog2(COS_TABLE_DEPTH + 1);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [23:0] PROG_MAX = 24'hFFFFFF;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STATUS_IDLE = 3'd0,
        STATUS_RAMP = 3'd1,
        STATUS_CONV = 3'd2,
        STATUS_HOLD = 3'd3,
        STATUS_BAD  = 3'd4
    } t_status;

    localparam logic [1:0] KIND_COS = 2'd0;
    localparam logic [1:0] KIND_LIN = 2'd1;

    localparam logic [7:0] CFG_RAMP_TIME = 8'd0;
    localparam logic [7:0] CFG_HOLD_TIME = 8'd1;
    localparam logic [7:0] CFG_AUTO_REP  = 8'd2;
    localparam logic [7:0] CFG_CONV_EN   = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_DIV,
        ST_FREEZE,
        ST_PROD,
        ST_EVAL,
        ST_RD,
        ST_MUL,
        ST_WR
    } t_state;

    // what the channel sweep does to each entry
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_COPY,
        ACT_RAMP,
        ACT_TARGET,
        ACT_SETTLE
    } t_act;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target;
        logic [31:0] current;
        logic [31:0] start;
    } t_chan_entry;

    typedef logic [16:0] t_cos_tab [COS_TABLE_DEPTH + 1];

    // quarter-wave cosine in Q16, Q30 Taylor series with eleven terms
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = 64'(k) * HALF_PI_Q30 / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = signed'(term);
            term = ((term * x2) >> 30) / 2;   sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 12;  sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 30;  sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 56;  sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 90;  sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 132; sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 182; sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 240; sum = sum + signed'(term);
            term = ((term * x2) >> 30) / 306; sum = sum - signed'(term);
            term = ((term * x2) >> 30) / 380; sum = sum + signed'(term);
            if (sum < 0) sum = 0;
            if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
            tab[k] = 17'((64'(sum) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage
`default_nettype wire

FILE: rtl/core/multichannel_ramp_hold_generator_unit.sv
`default_nettype none
// Ramp and hold setpoint generator. Every input word (tick, target load, start, stop)
// yields one output word per channel for channels 0 .. min(CHANNELS,8)-1, the last one
// flagged with tlast. Channel state (start, current, target, wave kind) lives in one
// single-port memory that is swept one entry at a time: read, multiply, write back.
// A running tick that divides first runs the bit-serial progress divider (24 steps),
// then product and evaluate; a paused or converging tick runs freeze, product and
// evaluate; a tick whose progress saturates runs product and evaluate; an output stall
// holds the sweep. Entries come out of reset as zero through per-entry valid bits; no
// clearing pass is needed. A new word is taken only once the sweep of the previous one
// has finished.
module multichannel_ramp_hold_generator_unit #(
    parameter int CHANNELS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // cfg write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // input words
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // now_ms[31:0], pause[32], release_convergence[33], channel[36:34],
    // target_value[68:37], wave_kind[70:69], zero[71]
    input  wire  [71:0] i_s_tdata,
    // opcode[1:0]
    input  wire  [1:0]  i_s_tuser,
    // result words
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // out_channel[2:0], signal_value[34:3], status[37:35], progress[61:38],
    // running[62], zero[63]
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast
);
    import mrhg_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_COUNT = (CHANNELS < 8) ? CHANNELS : 8;
    localparam logic [CW-1:0] LAST_IDX = CW'(CHANNELS - 1);
    localparam logic [CW-1:0] OUT_LAST = CW'(OUT_COUNT - 1);

    t_state r_state, n_state;

    t_opcode     r_op;
    logic [31:0] r_now;
    logic        r_pause, r_release;
    logic [2:0]  r_ch;
    logic [31:0] r_tval;
    logic [1:0]  r_kind;

    logic [15:0] r_ramp, r_hold;
    logic        r_auto, r_conv_en;

    logic        r_running, r_trig, r_converging;
    logic [31:0] r_start_ms;
    logic [23:0] r_prog;
    logic [2:0]  r_status;
    t_act        r_act;

    logic [15:0] r_div_rem;
    logic [23:0] r_div_q;
    logic [4:0]  r_div_cnt;
    logic [39:0] r_mprod;
    logic [17:0] r_w;

    t_chan_entry r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_mem_vld;
    t_chan_entry r_rd;
    logic        r_rd_vld;
    t_chan_entry r_ent;
    logic signed [51:0] r_cprod;
    logic [CW-1:0] r_idx;

    logic        r_ovalid, r_olast;
    logic [63:0] r_odata;

    // combinational helpers
    logic        w_conv_eff, w_emit, w_proceed, w_wr_en, w_sat, w_busy_tick;
    logic [31:0] w_el;
    logic [16:0] w_div_t;
    logic        w_div_bit;
    logic [15:0] w_div_rem;
    logic [16:0] w_u;
    logic [31:0] w_kk;
    logic [TAB_AW-1:0] w_k;
    t_chan_entry w_ent, w_new;
    logic signed [32:0] w_diff;
    logic signed [18:0] w_mop;
    logic signed [51:0] w_rnd;
    logic [31:0] w_v;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tlast   = r_olast;

    assign w_conv_eff  = r_converging && !r_release;
    assign w_el        = r_now - r_start_ms;
    assign w_sat       = (w_el >= 32'({r_ramp, 8'h00}));
    assign w_busy_tick = (r_op == OP_TICK) && r_running && (r_ramp != 16'd0) && !r_trig;

    assign w_div_t   = {r_div_rem, r_div_q[23]};
    assign w_div_bit = (w_div_t >= {1'b0, r_ramp});
    assign w_div_rem = w_div_bit ? 16'(w_div_t - {1'b0, r_ramp}) : w_div_t[15:0];

    // nearest table entry, mirrored above one half
    assign w_u  = (r_prog[16:0] <= 17'd32768) ? r_prog[16:0] : 17'(ONE_Q16 - r_prog[16:0]);
    assign w_kk = (32'(w_u) * 32'(2 * COS_TABLE_DEPTH) + 32'd32768) >> 16;
    assign w_k  = (w_kk > 32'(COS_TABLE_DEPTH)) ? TAB_AW'(COS_TABLE_DEPTH) : TAB_AW'(w_kk);

    assign w_ent  = r_rd_vld ? r_rd : '0;
    assign w_diff = signed'({w_ent.target[31], w_ent.target})
                  - signed'({w_ent.start[31], w_ent.start});
    assign w_mop  = (w_ent.kind == KIND_COS) ? signed'({1'b0, r_w})
                                              : signed'({2'b00, r_prog[16:0]});

    assign w_rnd = (r_ent.kind == KIND_COS) ? ((r_cprod + 52'sd65536) >>> 17)
                                             : ((r_cprod + 52'sd32768) >>> 16);
    assign w_v   = r_ent.start + w_rnd[31:0];

    always_comb begin
        w_new = r_ent;
        unique case (r_act)
            ACT_NONE: ;
            ACT_LOAD: begin
                if ((32'(r_ch) < CHANNELS) && (32'(r_ch) == 32'(r_idx))) begin
                    w_new.target = r_tval;
                    w_new.kind   = r_kind;
                end
            end
            ACT_COPY: w_new.start = r_ent.current;
            ACT_RAMP: begin
                if (r_ent.kind == KIND_COS || r_ent.kind == KIND_LIN) begin
                    w_new.current = w_v;
                end
            end
            ACT_TARGET: w_new.current = r_ent.target;
            ACT_SETTLE: begin
                w_new.current = r_ent.target;
                w_new.start   = r_ent.target;
            end
            default: ;
        endcase
    end

    assign w_emit    = (32'(r_idx) < OUT_COUNT);
    assign w_proceed = (r_state == ST_WR) && (!w_emit || !r_ovalid || i_m_tready);
    assign w_wr_en   = w_proceed;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_s_tvalid) begin
                n_state = ST_CMD;
            end
            ST_CMD: begin
                if (!w_busy_tick) begin
                    n_state = ST_RD;
                end else if (r_pause || w_conv_eff) begin
                    n_state = ST_FREEZE;
                end else if (w_sat) begin
                    n_state = ST_PROD;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: if (r_div_cnt == 5'd1) begin
                n_state = ST_PROD;
            end
            ST_FREEZE: n_state = ST_PROD;
            ST_PROD:   n_state = ST_EVAL;
            ST_EVAL:   n_state = ST_RD;
            ST_RD:     n_state = ST_MUL;
            ST_MUL:    n_state = ST_WR;
            ST_WR: if (w_proceed) begin
                n_state = (r_idx == LAST_IDX) ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp    <= 16'd1000;
            r_hold    <= 16'd0;
            r_auto    <= 1'b0;
            r_conv_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RAMP_TIME: r_ramp    <= i_cfg_data;
                CFG_HOLD_TIME: r_hold    <= i_cfg_data;
                CFG_AUTO_REP:  r_auto    <= i_cfg_data[0];
                CFG_CONV_EN:   r_conv_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_op      <= t_opcode'(i_s_tuser);
            r_now     <= i_s_tdata[31:0];
            r_pause   <= i_s_tdata[32];
            r_release <= i_s_tdata[33];
            r_ch      <= i_s_tdata[36:34];
            r_tval    <= i_s_tdata[68:37];
            r_kind    <= i_s_tdata[70:69];
        end
    end

    // scalar control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_trig       <= 1'b0;
            r_converging <= 1'b0;
            r_start_ms   <= 32'd0;
            r_prog       <= 24'd0;
            r_status     <= STATUS_IDLE;
            r_act        <= ACT_NONE;
        end else begin
            unique case (r_state)
                ST_CMD: begin
                    r_act <= ACT_NONE;
                    unique case (r_op)
                        OP_LOAD:  r_act <= ACT_LOAD;
                        OP_START: begin
                            r_running <= 1'b1;
                            r_trig    <= 1'b1;
                        end
                        OP_STOP:  r_running <= 1'b0;
                        OP_TICK: begin
                            r_converging <= w_conv_eff;
                            if (!r_running) begin
                                r_trig   <= 1'b0;
                                r_status <= STATUS_IDLE;
                                r_act    <= ACT_COPY;
                            end else if (r_ramp == 16'd0) begin
                                r_running <= 1'b0;
                                r_status  <= STATUS_BAD;
                            end else if (r_trig) begin
                                r_start_ms <= r_now;
                                r_trig     <= 1'b0;
                            end else if (!(r_pause || w_conv_eff) && w_sat) begin
                                r_prog <= PROG_MAX;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DIV: if (r_div_cnt == 5'd1) begin
                    r_prog <= {r_div_q[22:0], w_div_bit};
                end
                ST_FREEZE: r_start_ms <= r_now - 32'(r_mprod[39:16]);
                ST_EVAL: begin
                    if (r_prog < 24'(ONE_Q16)) begin
                        r_act    <= ACT_RAMP;
                        r_status <= STATUS_RAMP;
                    end else if (r_conv_en && (r_status == STATUS_RAMP || r_converging)) begin
                        r_converging <= 1'b1;
                        r_status     <= STATUS_CONV;
                        r_act        <= ACT_SETTLE;
                    end else if (r_hold != 16'd0 && r_prog != PROG_MAX
                                 && r_mprod < 40'({17'(r_ramp) + 17'(r_hold), 16'h0000})) begin
                        r_status <= STATUS_HOLD;
                        r_act    <= ACT_TARGET;
                    end else begin
                        // cycle complete: settle, then re-arm or stop
                        r_act    <= ACT_SETTLE;
                        r_trig   <= 1'b1;
                        r_prog   <= 24'd0;
                        r_status <= STATUS_IDLE;
                        if (r_auto) begin
                            r_start_ms <= r_now;
                        end else begin
                            r_running <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // divider, products and cosine weight
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CMD: begin
                r_div_rem <= w_el[23:8];
                r_div_q   <= {w_el[7:0], 16'h0000};
                r_div_cnt <= 5'd24;
                r_mprod   <= 40'(r_prog) * 40'(r_ramp);
            end
            ST_DIV: begin
                r_div_rem <= w_div_rem;
                r_div_q   <= {r_div_q[22:0], w_div_bit};
                r_div_cnt <= r_div_cnt - 5'd1;
            end
            ST_PROD: begin
                r_mprod <= 40'(r_prog) * 40'(r_ramp);
                r_w     <= (r_prog[16:0] <= 17'd32768) ? 18'(ONE_Q16) - 18'(COS_TAB[w_k])
                                                       : 18'(ONE_Q16) + 18'(COS_TAB[w_k]);
            end
            default: ;
        endcase
    end

    // channel sweep: one entry in flight, written back before the next read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (r_state == ST_EVAL || (r_state == ST_CMD && !w_busy_tick)) begin
            r_idx <= '0;
        end else if (w_proceed && r_idx != LAST_IDX) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            r_rd <= r_mem[r_idx];
        end
        if (w_wr_en) begin
            r_mem[r_idx] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (r_state == ST_RD) begin
                r_rd_vld <= r_mem_vld[r_idx];
            end
            if (w_wr_en) begin
                r_mem_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_ent   <= w_ent;
            r_cprod <= w_diff * w_mop;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else if (w_proceed && w_emit) begin
            r_ovalid <= 1'b1;
            r_olast  <= (r_idx == OUT_LAST);
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && w_emit) begin
            r_odata <= {1'b0, r_running, r_prog, r_status, w_new.current, 3'(r_idx)};
        end
    end

`include "multichannel_ramp_hold_generator_unit_macros.svh"

    `MRHG_ASSERT_NXT(a_accept_to_cmd, (i_s_tvalid && o_s_tready), (r_state == ST_CMD), "accepted word did not enter command decode")
    `MRHG_ASSERT_IMP(a_div_rem_bound, (r_state == ST_DIV), (r_div_rem < r_ramp), "divider remainder not below ramp time")
    `MRHG_ASSERT_IMP(a_no_wr_on_stall, (r_state == ST_WR && w_emit && r_ovalid && !i_m_tready), (!w_wr_en), "entry written while result stalled")

endmodule
`default_nettype wire
